// ----- hw/rtl/cisk_pkg.sv -----
// ----------------------------------------------------------------------------
// cisk_pkg
// Types and constants shared by the CBOR item skipper.
// ----------------------------------------------------------------------------
package cisk_pkg;

  localparam int LENGTH_BITS_DEF = 16;

  // Additional information codes that select a 1, 2, 4 or 8 byte argument.
  localparam logic [4:0] AI_MASK_TOP = 5'h1F;
  localparam logic [4:0] AI_ARG1     = 5'd24;
  localparam logic [4:0] AI_ARG2     = 5'd25;
  localparam logic [4:0] AI_ARG4     = 5'd26;
  localparam logic [4:0] AI_ARG8     = 5'd27;

  localparam logic [2:0] MT_UINT   = 3'd0;
  localparam logic [2:0] MT_NINT   = 3'd1;
  localparam logic [2:0] MT_BYTES  = 3'd2;
  localparam logic [2:0] MT_TEXT   = 3'd3;
  localparam logic [2:0] MT_ARRAY  = 3'd4;
  localparam logic [2:0] MT_MAP    = 3'd5;
  localparam logic [2:0] MT_SIMPLE = 3'd7;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_EOF = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEAD    = 2'd1,
    PH_ARG     = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } in_word_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [15:0] bytes_consumed;
  } result_t;

endpackage

// ----- hw/rtl/cisk_byte_if.sv -----
// ----------------------------------------------------------------------------
// cisk_byte_if
// Valid/ready channel that carries one buffer byte and its start mark.
// ----------------------------------------------------------------------------
interface cisk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

// ----- hw/rtl/cisk_result_if.sv -----
// ----------------------------------------------------------------------------
// cisk_result_if
// Valid/ready channel that carries one walk result.
// ----------------------------------------------------------------------------
interface cisk_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] bytes_consumed;

  modport source (output valid, output status, output bytes_consumed, input ready);
  modport sink (input valid, input status, input bytes_consumed, output ready);
endinterface

// ----- hw/rtl/cisk_in_stage.sv -----
// ----------------------------------------------------------------------------
// cisk_in_stage
// Input register: holds one accepted word until the walker takes it.
// ----------------------------------------------------------------------------
module cisk_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  cisk_pkg::in_word_t in_word,
  output logic               in_ready,
  input  logic               advance,
  output logic               word_valid,
  output cisk_pkg::in_word_t word
);
  import cisk_pkg::*;

  logic     held_valid;
  logic     held_valid_next;
  in_word_t held_word;
  logic     take;

  assign in_ready = !held_valid || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    if (take) begin
      held_valid_next = 1'b1;
    end else if (advance) begin
      held_valid_next = 1'b0;
    end else begin
      held_valid_next = held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_word <= in_word;
    end
  end

  assign word_valid = held_valid;
  assign word       = held_word;

endmodule

// ----- hw/rtl/cisk_walker.sv -----
// ----------------------------------------------------------------------------
// cisk_walker
// Walk state and the per-byte head, argument and payload decode.
// ----------------------------------------------------------------------------
module cisk_walker #(
  parameter int LENGTH_BITS = cisk_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  cisk_pkg::in_word_t word,
  input  logic [15:0]        bytes_available,
  output cisk_pkg::result_t  res
);
  import cisk_pkg::*;

  localparam int AW = LENGTH_BITS;

  phase_t         phase, phase_next, cur_phase;
  logic [3:0]     arg_left, arg_left_next;
  logic [63:0]    arg_val, arg_val_next;
  logic [2:0]     major_type, major_type_next;
  logic [AW-1:0]  consumed, consumed_next, cur_consumed;
  logic [31:0]    owed, owed_next, cur_owed;
  logic [AW-1:0]  payload_left, payload_left_next;

  logic [AW-1:0]  avail;
  logic [AW-1:0]  cons1;
  logic [AW-1:0]  remaining;
  logic [4:0]     ai;
  logic [3:0]     arg_n;
  logic [63:0]    val;
  logic [2:0]     mt;
  logic           head_end;
  logic           item_end;
  logic [31:0]    item_owed;
  logic [31:0]    owed_dec;
  logic           val_gt;
  logic [AW:0]    items;
  logic           items_gt;
  logic [33:0]    owed_sum;

  assign avail     = AW'(bytes_available);
  assign cons1     = cur_consumed + AW'(1);
  assign remaining = avail - cons1;
  assign ai        = word.data_byte[4:0] & AI_MASK_TOP;
  assign owed_dec  = cur_owed - 32'd1;

  // A start byte restarts the walk with one item owed.
  always_comb begin
    if (word.start_req) begin
      cur_phase    = PH_HEAD;
      cur_consumed = '0;
      cur_owed     = 32'd1;
    end else begin
      cur_phase    = phase;
      cur_consumed = consumed;
      cur_owed     = owed;
    end
  end

  always_comb begin
    case (ai)
      AI_ARG1: arg_n = 4'd1;
      AI_ARG2: arg_n = 4'd2;
      AI_ARG4: arg_n = 4'd4;
      AI_ARG8: arg_n = 4'd8;
      default: arg_n = 4'd0;
    endcase
  end

  // Argument value and major type of the head that this byte may complete.
  always_comb begin
    case (cur_phase)
      PH_HEAD: begin
        val = 64'(ai);
        mt  = word.data_byte[7:5];
      end
      PH_ARG: begin
        val = {arg_val[55:0], word.data_byte};
        mt  = major_type;
      end
      default: begin
        val = arg_val;
        mt  = major_type;
      end
    endcase
  end

  assign val_gt   = (|val[63:AW]) || (val[AW-1:0] > remaining);
  assign items    = (mt == MT_MAP) ? {val[AW-1:0], 1'b0} : {1'b0, val[AW-1:0]};
  assign items_gt = items > {1'b0, remaining};
  assign owed_sum = 34'(owed_dec) + 34'(items);

  always_comb begin
    phase_next        = cur_phase;
    consumed_next     = cur_consumed;
    owed_next         = cur_owed;
    arg_left_next     = arg_left;
    arg_val_next      = arg_val;
    major_type_next   = major_type;
    payload_left_next = payload_left;
    res               = '0;
    head_end          = 1'b0;
    item_end          = 1'b0;
    item_owed         = cur_owed;

    if (cur_phase != PH_IDLE) begin
      if (cur_consumed >= avail) begin
        res.valid          = 1'b1;
        res.status         = ST_EOF;
        res.bytes_consumed = 16'(cur_consumed);
        phase_next         = PH_IDLE;
      end else begin
        consumed_next = cons1;
        case (cur_phase)
          PH_HEAD: begin
            major_type_next = word.data_byte[7:5];
            if (ai < AI_ARG1) begin
              head_end = 1'b1;
            end else if (arg_n == 4'd0) begin
              res.valid          = 1'b1;
              res.status         = ST_BAD;
              res.bytes_consumed = 16'(cons1);
              phase_next         = PH_IDLE;
            end else if (({1'b0, cons1} + (AW+1)'(arg_n)) > {1'b0, avail}) begin
              res.valid          = 1'b1;
              res.status         = ST_EOF;
              res.bytes_consumed = 16'(cons1);
              phase_next         = PH_IDLE;
            end else begin
              arg_val_next  = '0;
              arg_left_next = arg_n;
              phase_next    = PH_ARG;
            end
          end
          PH_ARG: begin
            arg_val_next  = val;
            arg_left_next = arg_left - 4'd1;
            head_end      = (arg_left == 4'd1);
          end
          PH_PAYLOAD: begin
            payload_left_next = payload_left - AW'(1);
            item_end          = (payload_left == AW'(1));
          end
          default: begin
          end
        endcase
      end
    end

    // A head is complete: account for strings and containers.
    if (head_end) begin
      owed_next = owed_dec;
      item_owed = owed_dec;
      case (mt)
        MT_UINT, MT_NINT, MT_SIMPLE: begin
          item_end = 1'b1;
        end
        MT_BYTES, MT_TEXT: begin
          if (val_gt) begin
            res.valid          = 1'b1;
            res.status         = ST_EOF;
            res.bytes_consumed = 16'(cons1);
            phase_next         = PH_IDLE;
          end else if (val[AW-1:0] != '0) begin
            payload_left_next = val[AW-1:0];
            phase_next        = PH_PAYLOAD;
          end else begin
            item_end = 1'b1;
          end
        end
        MT_ARRAY, MT_MAP: begin
          if (val_gt || items_gt) begin
            res.valid          = 1'b1;
            res.status         = ST_BAD;
            res.bytes_consumed = 16'(cons1);
            phase_next         = PH_IDLE;
          end else begin
            item_owed = (|owed_sum[33:32]) ? '1 : owed_sum[31:0];
            owed_next = item_owed;
            item_end  = 1'b1;
          end
        end
        default: begin
          res.valid          = 1'b1;
          res.status         = ST_BAD;
          res.bytes_consumed = 16'(cons1);
          phase_next         = PH_IDLE;
        end
      endcase
    end

    // An item's bytes are done: finish, run out, or wait for the next head.
    if (item_end) begin
      if (item_owed == '0) begin
        res.valid          = 1'b1;
        res.status         = ST_OK;
        res.bytes_consumed = 16'(cons1);
        phase_next         = PH_IDLE;
      end else if (cons1 >= avail) begin
        res.valid          = 1'b1;
        res.status         = ST_EOF;
        res.bytes_consumed = 16'(cons1);
        phase_next         = PH_IDLE;
      end else begin
        phase_next = PH_HEAD;
      end
    end

    if (!fire) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      consumed     <= '0;
      owed         <= '0;
      arg_left     <= '0;
      arg_val      <= '0;
      major_type   <= '0;
      payload_left <= '0;
    end else if (fire) begin
      phase        <= phase_next;
      consumed     <= consumed_next;
      owed         <= owed_next;
      arg_left     <= arg_left_next;
      arg_val      <= arg_val_next;
      major_type   <= major_type_next;
      payload_left <= payload_left_next;
    end
  end

endmodule

// ----- hw/rtl/cisk_out_stage.sv -----
// ----------------------------------------------------------------------------
// cisk_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module cisk_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  cisk_pkg::result_t res,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [15:0]       out_bytes_consumed
);
  import cisk_pkg::*;

  logic        held_valid;
  logic        held_valid_next;
  status_t     held_status;
  logic [15:0] held_consumed;

  // The walker may move on whenever the register is empty or being emptied.
  assign advance = !held_valid || out_ready;

  always_comb begin
    if (advance) begin
      held_valid_next = res.valid;
    end else begin
      held_valid_next = held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      held_status   <= res.status;
      held_consumed <= res.bytes_consumed;
    end
  end

  assign out_valid          = held_valid;
  assign out_status         = held_status;
  assign out_bytes_consumed = held_consumed;

endmodule

// ----- hw/rtl/cbor_item_skipper_unit.sv -----
// ----------------------------------------------------------------------------
// cbor_item_skipper_unit
// Finds the end of one CBOR data item in a byte stream, one byte per cycle.
// ----------------------------------------------------------------------------
// The unit takes one byte word per cycle with no gaps of its own. A word is
// held in an input register, decoded against the walk state, and any result
// lands in a result register, so each result comes out of the input register
// and then the result register behind the word that caused it. The per-byte
// update of the walk state (owed-item count, consumed count, argument shift)
// is the loop that sets this rate. When the result register is full and
// not taken, the input register holds and ready drops. Write bytes_available
// only between walks; it is counted from the byte marked start.
module cbor_item_skipper_unit #(
  parameter int LENGTH_BITS = cisk_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cisk_byte_if.sink   byte_ch,
  cisk_result_if.source result_ch,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata
);
  import cisk_pkg::*;

  logic [15:0] bytes_available;
  in_word_t    in_word;
  in_word_t    word;
  logic        word_valid;
  logic        advance;
  logic        fire;
  result_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_available <= 16'd1;
    end else if (cfg_wen) begin
      bytes_available <= cfg_wdata;
    end
  end

  assign in_word.data_byte = byte_ch.data_byte;
  assign in_word.start_req = byte_ch.start_req;
  assign fire              = word_valid && advance;

  cisk_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_ch.valid),
    .in_word   (in_word),
    .in_ready  (byte_ch.ready),
    .advance   (advance),
    .word_valid(word_valid),
    .word      (word)
  );

  cisk_walker #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_walker (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .word           (word),
    .bytes_available(bytes_available),
    .res            (res)
  );

  cisk_out_stage u_out_stage (
    .clk               (clk),
    .rst               (rst),
    .res               (res),
    .advance           (advance),
    .out_valid         (result_ch.valid),
    .out_ready         (result_ch.ready),
    .out_status        (result_ch.status),
    .out_bytes_consumed(result_ch.bytes_consumed)
  );

endmodule

// ----- hw/rtl/cisk_checker.sv -----
// ----------------------------------------------------------------------------
// cisk_checker
// Port-level checks on the item skipper, bound to the top level.
// ----------------------------------------------------------------------------
module cisk_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_bytes_consumed
);
  import cisk_pkg::*;

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)
                                   && $stable(out_bytes_consumed)))
    else $error("stalled result changed");

  // A completed item always took at least its head byte.
  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_OK) |-> (out_bytes_consumed != 16'd0))
    else $error("complete item with zero bytes");

  // A new result needs an accepted word that has passed through the input register.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!$past(in_acc, 2) && !$past(out_valid)) |-> !out_valid)
    else $error("result without a word");

endmodule

bind cbor_item_skipper_unit cisk_checker u_cisk_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (byte_ch.valid),
  .in_ready          (byte_ch.ready),
  .out_valid         (result_ch.valid),
  .out_ready         (result_ch.ready),
  .out_status        (result_ch.status),
  .out_bytes_consumed(result_ch.bytes_consumed)
);

// ----- sim/tb_cbor_item_skipper_unit.sv -----
// ----------------------------------------------------------------------------
// tb_cbor_item_skipper_unit
// Checks the CBOR item skipper against a cycle-free model of the item walk.
// Byte words come from a queue that the stimulus process fills one buffer
// setting at a time. A clocked driver sends them in random bursts. A clocked
// monitor stalls the result channel on its own pattern and compares every
// result with the walk results that the model predicted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cbor_item_skipper_unit;
  import cisk_pkg::*;

  localparam logic [2:0] MT_TAG       = 3'd6;
  localparam logic [4:0] AI_FIRST_BAD = 5'd28;
  localparam logic [4:0] AI_INDEF     = 5'd31;
  localparam int         IDLE_GAP     = 8;
  localparam int         LONG_HOLD    = 300;
  localparam int         WALK_BYTES   = 64;

  typedef struct {
    status_t     st;
    logic [15:0] used;
  } walk_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;

  logic        drv_valid = 1'b0;
  in_word_t    drv_word = '0;
  logic        drv_ready = 1'b0;

  cisk_byte_if   byte_ch ();
  cisk_result_if result_ch ();

  assign byte_ch.valid     = drv_valid;
  assign byte_ch.data_byte = drv_word.data_byte;
  assign byte_ch.start_req = drv_word.start_req;
  assign result_ch.ready   = drv_ready;

  cbor_item_skipper_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  in_word_t     byte_words_q[$];
  walk_result_t walk_results_q[$];
  logic [7:0]   gen_buf[$];
  int           fail_count = 0;

  // Walk state of the model and the buffer length it reads.
  logic [15:0] avail_cfg = 16'd1;
  phase_t      w_phase = PH_IDLE;
  logic [3:0]  w_arg_left;
  logic [63:0] w_arg_val;
  logic [2:0]  w_major;
  logic [15:0] w_consumed;
  logic [31:0] w_owed;
  logic [15:0] w_payload;

  function automatic void walk_reset();
    w_phase    = PH_IDLE;
    w_arg_left = '0;
    w_arg_val  = '0;
    w_major    = '0;
    w_consumed = '0;
    w_owed     = '0;
    w_payload  = '0;
  endfunction

  function automatic void report_walk(status_t s);
    walk_result_t r;
    r.st   = s;
    r.used = w_consumed;
    walk_results_q.push_back(r);
    w_phase = PH_IDLE;
  endfunction

  function automatic void close_item();
    if (w_owed == 0) report_walk(ST_OK);
    else if (w_consumed >= avail_cfg) report_walk(ST_EOF);
    else w_phase = PH_HEAD;
  endfunction

  function automatic void close_head();
    logic [63:0] left;
    logic [63:0] cnt;
    logic [64:0] sum;
    left   = {48'd0, avail_cfg - w_consumed};
    w_owed = w_owed - 32'd1;
    case (w_major)
      MT_UINT, MT_NINT, MT_SIMPLE: close_item();
      MT_BYTES, MT_TEXT: begin
        if (w_arg_val > left) report_walk(ST_EOF);
        else if (w_arg_val != 0) begin
          w_payload = w_arg_val[15:0];
          w_phase   = PH_PAYLOAD;
        end else close_item();
      end
      MT_ARRAY, MT_MAP: begin
        // A map owes a key and a value per entry.
        cnt = (w_major == MT_MAP) ? (w_arg_val << 1) : w_arg_val;
        if (w_arg_val > left || cnt > left) report_walk(ST_BAD);
        else begin
          sum    = w_owed + cnt;
          w_owed = (sum > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
          close_item();
        end
      end
      default: report_walk(ST_BAD);
    endcase
  endfunction

  function automatic void walk_step(logic [7:0] b, logic s);
    logic [4:0] ai;
    if (s) begin
      w_phase    = PH_HEAD;
      w_consumed = '0;
      w_owed     = 32'd1;
      w_arg_left = '0;
      w_arg_val  = '0;
      w_payload  = '0;
    end
    if (w_phase == PH_IDLE) return;
    if (w_consumed >= avail_cfg) begin
      report_walk(ST_EOF);
      return;
    end
    w_consumed = w_consumed + 16'd1;
    case (w_phase)
      PH_HEAD: begin
        ai      = b[4:0];
        w_major = b[7:5];
        if (ai < AI_ARG1) begin
          w_arg_val = {59'd0, ai};
          close_head();
        end else if (ai > AI_ARG8) report_walk(ST_BAD);
        else begin
          w_arg_left = (ai == AI_ARG1) ? 4'd1 : (ai == AI_ARG2) ? 4'd2 :
                       (ai == AI_ARG4) ? 4'd4 : 4'd8;
          if ({1'b0, w_consumed} + w_arg_left > {1'b0, avail_cfg}) report_walk(ST_EOF);
          else begin
            w_arg_val = '0;
            w_phase   = PH_ARG;
          end
        end
      end
      PH_ARG: begin
        w_arg_val  = {w_arg_val[55:0], b};
        w_arg_left = w_arg_left - 4'd1;
        if (w_arg_left == 0) close_head();
      end
      default: begin
        w_payload = w_payload - 16'd1;
        if (w_payload == 0) close_item();
      end
    endcase
  endfunction

  // Stimulus helpers.
  function automatic void push_word(logic [7:0] b, logic s);
    in_word_t w;
    w.data_byte = b;
    w.start_req = s;
    byte_words_q.push_back(w);
  endfunction

  function automatic void put_head(logic [2:0] mt, logic [63:0] val);
    int         n;
    logic [4:0] ai;
    if (val < 24) n = 0;
    else if (val < 256) n = 1;
    else if (val < 65536) n = 2;
    else if (val < 64'h1_0000_0000) n = 4;
    else n = 8;
    // Now and then use a wider argument than the value needs.
    if (n < 8 && $urandom_range(0, 5) == 0) n = (n == 0) ? 1 : n * 2;
    case (n)
      0:       ai = val[4:0];
      1:       ai = AI_ARG1;
      2:       ai = AI_ARG2;
      4:       ai = AI_ARG4;
      default: ai = AI_ARG8;
    endcase
    gen_buf.push_back({mt, ai});
    for (int k = n - 1; k >= 0; k--) gen_buf.push_back(val[8*k +: 8]);
  endfunction

  function automatic logic [63:0] pick_arg();
    case ($urandom_range(0, 9))
      0:       return 64'd23;
      1:       return 64'd24;
      2:       return 64'hFF;
      3:       return 64'h100;
      4:       return 64'hFFFF;
      5:       return 64'hFFFF_FFFF;
      6:       return 64'hFFFF_FFFF_FFFF_FFFF;
      7:       return {$urandom, $urandom};
      default: return 64'($urandom_range(0, 300));
    endcase
  endfunction

  // Builds one item in gen_buf, mostly well formed, by tracking owed items.
  function automatic void gen_walk();
    int          owed;
    int          kind;
    int          cnt;
    logic [63:0] len;
    owed = 1;
    while (owed > 0) begin
      owed--;
      kind = $urandom_range(0, 19);
      cnt  = (gen_buf.size() < 20 && owed < 6) ? $urandom_range(0, 3) : 0;
      if (kind < 4) put_head(MT_UINT, pick_arg());
      else if (kind < 6) put_head(MT_NINT, pick_arg());
      else if (kind < 8) put_head(MT_SIMPLE, 64'($urandom_range(0, 40)));
      else if (kind < 11) begin
        len = 64'($urandom_range(0, 6));
        put_head(kind[0] ? MT_TEXT : MT_BYTES, len);
        repeat (len) gen_buf.push_back(8'($urandom));
      end else if (kind < 14) begin
        put_head(MT_ARRAY, 64'(cnt));
        owed += cnt;
      end else if (kind < 16) begin
        put_head(MT_MAP, 64'(cnt));
        owed += 2 * cnt;
      end else if (kind == 16) begin
        put_head(MT_TAG, 64'($urandom_range(0, 30)));
        owed++;
      end else if (kind == 17) begin
        gen_buf.push_back({3'($urandom), 5'($urandom_range(AI_FIRST_BAD, AI_INDEF))});
      end else if (kind == 18) begin
        put_head($urandom_range(0, 1) ? MT_TEXT : MT_BYTES, {$urandom, $urandom} | 64'h1_0000);
      end else begin
        put_head($urandom_range(0, 1) ? MT_ARRAY : MT_MAP, pick_arg());
      end
    end
  endfunction

  // Queues one walk: sometimes raw noise, sometimes cut short, sometimes
  // followed by stray bytes. Returns the number of walk bytes queued.
  function automatic int load_walk();
    int cut;
    int n;
    gen_buf.delete();
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 8)) gen_buf.push_back(8'($urandom));
    else gen_walk();
    cut = gen_buf.size();
    if (cut > 1 && $urandom_range(0, 7) == 0) cut = $urandom_range(1, cut - 1);
    for (int i = 0; i < cut; i++) push_word(gen_buf[i], i == 0);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    for (int i = 0; i < n; i++) push_word(8'($urandom), 1'b0);
    return cut;
  endfunction

  // Sampled at the falling edge so that the driver's updates have settled.
  task automatic wait_walks_done();
    while (byte_words_q.size() != 0 || drv_valid) @(negedge clk);
    while (walk_results_q.size() != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic set_avail(logic [15:0] v);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    avail_cfg = v;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Driver: sends queued words in bursts and predicts each accepted word.
  int gap_left = 0;
  int burst_left = 1;

  always @(posedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
      walk_reset();
      gap_left   = 0;
      burst_left = 1;
    end else begin
      if (drv_valid && byte_ch.ready) walk_step(drv_word.data_byte, drv_word.start_req);
      if (!drv_valid || byte_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (byte_words_q.size() != 0) begin
          drv_word  <= byte_words_q.pop_front();
          drv_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results and stalls the result channel.
  int          results_seen = 0;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;
  int          pat_age = 0;
  logic [15:0] stall_pat = 16'hFFFF;

  always @(posedge clk) begin
    walk_result_t exp_res;
    if (rst) begin
      drv_ready <= 1'b0;
    end else begin
      if (result_ch.valid && drv_ready) begin
        if (walk_results_q.size() == 0) begin
          $error("unexpected result word: status %0d, bytes_consumed %0d",
                 result_ch.status, result_ch.bytes_consumed);
          fail_count++;
        end else begin
          exp_res = walk_results_q.pop_front();
          results_seen++;
          if (result_ch.status !== exp_res.st) begin
            $error("status: expected %0d, actual %0d", exp_res.st, result_ch.status);
            fail_count++;
          end
          if (result_ch.bytes_consumed !== exp_res.used) begin
            $error("bytes_consumed: expected %0d, actual %0d", exp_res.used,
                   result_ch.bytes_consumed);
            fail_count++;
          end
        end
      end
      // One long hold while plenty of words are still waiting, so that the
      // result register fills and the input side backs up.
      if (hold_left != 0) hold_left--;
      else if (!long_hold_done && results_seen >= 40 && byte_words_q.size() > 30) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      pat_age++;
      if (pat_age == 40) begin
        pat_age   = 0;
        stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      end else begin
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
      drv_ready <= (hold_left == 0) && stall_pat[0];
    end
  end

  initial begin
    int made;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // A one-byte buffer: only a lone short head fits.
    set_avail(16'd1);
    push_word(8'h00, 1'b0);  // no walk yet, so this word is ignored
    push_word(8'h00, 1'b1);
    push_word(8'h20, 1'b1);
    push_word(8'h18, 1'b1);  // argument byte would pass the end
    push_word(8'h81, 1'b1);  // array count above the bytes left
    push_word({MT_UINT, AI_FIRST_BAD}, 1'b1);
    push_word(8'hFF, 1'b0);  // after a result, ignored
    wait_walks_done();

    set_avail(16'hFFFF);
    push_word(8'hFF, 1'b1);  // indefinite length
    push_word(8'hC0, 1'b1);  // tag
    push_word({MT_UINT, AI_ARG8}, 1'b1);
    repeat (8) push_word(8'hFF, 1'b0);
    push_word(8'h62, 1'b1);
    push_word(8'h41, 1'b0);
    push_word(8'h42, 1'b0);
    push_word({MT_BYTES, AI_ARG4}, 1'b1);  // payload longer than the buffer
    repeat (4) push_word(8'hFF, 1'b0);
    push_word(8'hA1, 1'b1);
    push_word(8'h01, 1'b0);
    push_word(8'h02, 1'b0);
    push_word(8'h82, 1'b1);
    push_word(8'h00, 1'b1);  // a new start abandons the open array
    wait_walks_done();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       set_avail(16'hFFFF);
        1:       set_avail(16'($urandom_range(2, 12)));
        2:       set_avail(16'd1);
        3:       set_avail(16'($urandom_range(13, 60)));
        4:       set_avail(16'($urandom_range(61, 65534)));
        default: set_avail(16'hFFFF);
      endcase
      made = 0;
      while (made < WALK_BYTES) made += load_walk();
      wait_walks_done();
    end

    if (fail_count == 0 && walk_results_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
